// ===== rtl/core/css_pkg.sv =====
package css_pkg;

   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_STAR      = 8'h2A;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;

   // Result queue: depth and index widths.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      MODE_CODE   = 4'b0001,
      MODE_STRING = 4'b0010,
      MODE_LINE   = 4'b0100,
      MODE_BLOCK  = 4'b1000
   } mode_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       last_out;
   } result_type;

endpackage

// ===== rtl/core/css_req_if.sv =====
interface css_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       last_in;

   modport source (output valid, output ch, output last_in, input ready);
   modport sink   (input valid, input ch, input last_in, output ready);
endinterface

// ===== rtl/core/css_rsp_if.sv =====
interface css_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       has_byte;
   logic       last_out;

   modport source (output valid, output out_byte, output has_byte, output last_out,
                   input ready);
   modport sink   (input valid, input out_byte, input has_byte, input last_out,
                   output ready);
endinterface

// ===== rtl/core/comment_stripper_stream.sv =====
// Comment stripper for a stream of source text.
//
// Text bytes arrive on req_stream, one item per byte, with last_in set on the
// final byte of a text. The comment-free text leaves on rsp_stream, one byte
// per item. Line comments and block comments are removed; double-quoted
// strings pass untouched. A slash in code, or a star in a block comment, is
// held back until the next byte decides it, so one input item can release
// two result items. The final result of a text always carries last_out, and
// when the final byte yields nothing a bare item with has_byte low is sent.
//
// Results of an accepted item are written into a four-entry result queue
// and offered on rsp_stream from there in order. Throughput is one item per
// cycle, set by the scanner logic between the input handshake and the queue,
// as long as the input is ready, which is while the queue has room for two
// results, so the block keeps accepting while a result waits to be taken.
// When the receiver stalls, the queue fills and req_stream.ready falls.
// Synchronous reset empties the queue and returns the scanner to code mode.
module comment_stripper_stream (
   input  logic      clock,
   input  logic      reset,
   css_req_if.sink   req_stream,
   css_rsp_if.source rsp_stream
);
   import css_pkg::*;

   // Scanner state.
   mode_type mode_ff, mode_in;
   logic     held_slash_ff, held_slash_in;
   logic     held_star_ff, held_star_in;
   logic     prev_bs_ff, prev_bs_in;

   // Result queue.
   result_type             queue_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]    count_ff, count_in;

   logic       accept;
   logic       pop;
   logic [7:0] b;
   logic       at_end;
   logic       is_quote_open;

   // Up to two results from one item.
   result_type res0, res1;
   logic [1:0] res_count;

   // Effect of a byte seen in code mode with no slash held.
   logic cb_emit;
   logic cb_hold;
   logic cb_string;

   assign b      = req_stream.ch;
   assign at_end = req_stream.last_in;

   // The queue must be able to take two results for a new item to enter.
   assign req_stream.ready = (count_ff <= QUEUE_CW'(QUEUE_DEPTH - 2));
   assign accept           = req_stream.valid && req_stream.ready;
   assign pop              = rsp_stream.valid && rsp_stream.ready;

   assign is_quote_open = (b == CH_QUOTE) && !prev_bs_ff;

   always_comb begin
      cb_string = 1'b0;
      cb_hold   = 1'b0;
      cb_emit   = 1'b0;
      if (is_quote_open) begin
         cb_string = 1'b1;
         cb_emit   = 1'b1;
      end else if ((b == CH_SLASH) && !at_end) begin
         cb_hold = 1'b1;
      end else begin
         cb_emit = 1'b1;
      end
   end

   always_comb begin
      mode_in       = mode_ff;
      held_slash_in = held_slash_ff;
      held_star_in  = held_star_ff;
      res0          = '{out_byte: b, has_byte: 1'b1, last_out: 1'b0};
      res1          = '{out_byte: b, has_byte: 1'b1, last_out: 1'b0};
      res_count     = 2'd0;

      case (mode_ff)
         MODE_CODE: begin
            if (held_slash_ff) begin
               held_slash_in = 1'b0;
               if (b == CH_SLASH) begin
                  mode_in = MODE_LINE;
               end else if (b == CH_STAR) begin
                  mode_in      = MODE_BLOCK;
                  held_star_in = 1'b0;
               end else begin
                  // The held slash was plain text; release it before this byte.
                  res0.out_byte = CH_SLASH;
                  res_count     = cb_emit ? 2'd2 : 2'd1;
                  held_slash_in = cb_hold;
                  if (cb_string) begin
                     mode_in = MODE_STRING;
                  end
               end
            end else begin
               res_count     = cb_emit ? 2'd1 : 2'd0;
               held_slash_in = cb_hold;
               if (cb_string) begin
                  mode_in = MODE_STRING;
               end
            end
         end
         MODE_STRING: begin
            if (is_quote_open) begin
               mode_in = MODE_CODE;
            end
            res_count = 2'd1;
         end
         MODE_LINE: begin
            if (b == CH_NEWLINE) begin
               mode_in   = MODE_CODE;
               res_count = 2'd1;
            end
         end
         MODE_BLOCK: begin
            if (held_star_ff && (b == CH_SLASH)) begin
               held_star_in = 1'b0;
               mode_in      = MODE_CODE;
            end else begin
               held_star_in = 1'b0;
               if (b == CH_STAR) begin
                  held_star_in = !at_end;
               end else if (b == CH_NEWLINE) begin
                  res_count = 2'd1;
               end
            end
         end
         default: begin
            mode_in = MODE_CODE;
         end
      endcase

      prev_bs_in = (b == CH_BACKSLASH);

      // End of text: mark the final result, or send a bare end mark, then
      // start the next text from a clean state.
      if (at_end) begin
         if (res_count == 2'd0) begin
            res0      = '{out_byte: 8'd0, has_byte: 1'b0, last_out: 1'b1};
            res_count = 2'd1;
         end else if (res_count == 2'd1) begin
            res0.last_out = 1'b1;
         end else begin
            res1.last_out = 1'b1;
         end
         mode_in       = MODE_CODE;
         held_slash_in = 1'b0;
         held_star_in  = 1'b0;
         prev_bs_in    = 1'b0;
      end
   end

   // Queue pointer and count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept) begin
         wr_ptr_in = wr_ptr_ff + QUEUE_AW'(res_count);
         count_in  = count_in + QUEUE_CW'(res_count);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + QUEUE_AW'(1);
         count_in  = count_in - QUEUE_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_CODE;
         held_slash_ff <= 1'b0;
         held_star_ff  <= 1'b0;
         prev_bs_ff    <= 1'b0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         if (accept) begin
            mode_ff       <= mode_in;
            held_slash_ff <= held_slash_in;
            held_star_ff  <= held_star_in;
            prev_bs_ff    <= prev_bs_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage needs no reset; the count guards every read.
   always_ff @(posedge clock) begin
      if (accept) begin
         if (res_count != 2'd0) begin
            queue_ff[wr_ptr_ff] <= res0;
         end
         if (res_count == 2'd2) begin
            queue_ff[wr_ptr_ff + QUEUE_AW'(1)] <= res1;
         end
      end
   end

   assign rsp_stream.valid    = (count_ff != '0);
   assign rsp_stream.out_byte = queue_ff[rd_ptr_ff].out_byte;
   assign rsp_stream.has_byte = queue_ff[rd_ptr_ff].has_byte;
   assign rsp_stream.last_out = queue_ff[rd_ptr_ff].last_out;

endmodule
